// ----- hw/rtl/rlbe_pkg.sv -----
// Shared types and constants for the run-length block expander.
package rlbe_pkg;

    localparam int RUN_W       = 6;
    localparam int COEF_W      = 16;
    localparam int POS_W       = 6;
    localparam int CNT_W       = 7;
    localparam int MAX_RESULTS = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One expansion job handed from the front part to the back part.
    typedef struct packed {
        logic [POS_W-1:0]         start_pos;
        logic [CNT_W-1:0]         count;
        logic [RUN_W-1:0]         val_idx;
        logic signed [COEF_W-1:0] value;
        logic                     ovf;
    } rlbe_cmd_t;

endpackage

// ----- hw/rtl/run_length_block_expander_unit.sv -----
// Top level of the run-length block expander: zero-run pairs in, coefficients out.
//
//  Channel  Handshake            Payload
//  in       in_valid/in_ready    zero_run, coeff_value
//  out      out_valid/out_ready  coefficient, position, run_last, overflow
//
// Each request is taken into a two-entry job queue; the back part then emits one
// coefficient per cycle while the output is not stalled, 1 to 64 results per request,
// set by the single output counter. An end-of-block request into a full block is
// taken but gives no output.
// Reset clears the fill position, the queue and the output valid flag.
// Input stalls only when the queue is full; output stalls hold the result.
module run_length_block_expander_unit #(
    parameter int BLOCK_COEFFS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rlbe_pkg::RUN_W-1:0]          zero_run,
    input  logic signed [rlbe_pkg::COEF_W-1:0]  coeff_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rlbe_pkg::COEF_W-1:0]  coefficient,
    output logic [rlbe_pkg::POS_W-1:0]          position,
    output logic                                run_last,
    output logic                                overflow
);

    rlbe_pkg::rlbe_cmd_t cmd;
    rlbe_pkg::rlbe_cmd_t head;
    logic                push;
    logic                q_full;
    logic                pop;
    logic                head_valid;

    // Classification and fill tracking.
    rlbe_front #(
        .BLOCK_COEFFS(BLOCK_COEFFS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .zero_run   (zero_run),
        .coeff_value(coeff_value),
        .q_full     (q_full),
        .push       (push),
        .cmd        (cmd)
    );

    // Job queue.
    rlbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd_in    (cmd),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head      (head)
    );

    // Expansion and output register.
    rlbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .coefficient(coefficient),
        .position   (position),
        .run_last   (run_last),
        .overflow   (overflow)
    );

endmodule

// ----- hw/rtl/rlbe_front.sv -----
// Front part: accepts (run, value) requests, tracks the fill position, builds jobs.
module rlbe_front #(
    parameter int BLOCK_COEFFS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rlbe_pkg::RUN_W-1:0]         zero_run,
    input  logic signed [rlbe_pkg::COEF_W-1:0] coeff_value,
    input  logic                               q_full,
    output logic                               push,
    output rlbe_pkg::rlbe_cmd_t                cmd
);

    localparam int PW = $clog2(BLOCK_COEFFS + 1);
    localparam int CW = (PW > rlbe_pkg::CNT_W) ? PW : rlbe_pkg::CNT_W;
    localparam logic [PW-1:0] BLK = PW'(BLOCK_COEFFS);
    localparam logic [CW-1:0] MAXR = CW'(rlbe_pkg::MAX_RESULTS);

    logic [PW-1:0] fill_reg;
    logic [PW-1:0] fill_next;
    logic          accept;
    logic          is_eob;
    logic          is_full;
    logic [PW-1:0] room;
    logic [CW-1:0] room_w;
    logic [CW-1:0] need_w;
    logic [CW-1:0] eob_emit;
    logic [CW-1:0] emit;
    logic          cut;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // Classify the request and size the job.
    always_comb
    begin
        is_eob   = (zero_run == '0) && (coeff_value == '0);
        is_full  = (fill_reg == BLK);
        room     = BLK - fill_reg;
        room_w   = CW'(room);
        need_w   = CW'(zero_run) + CW'(1);
        eob_emit = (room_w > MAXR) ? MAXR : room_w;
        cut      = need_w > room_w;
        emit     = cut ? room_w : need_w;
    end

    // Job contents and fill position update.
    always_comb
    begin
        cmd       = '0;
        push      = 1'b0;
        fill_next = fill_reg;
        if (accept)
        begin
            if (is_eob)
            begin
                cmd.start_pos = rlbe_pkg::POS_W'(fill_reg);
                cmd.count     = rlbe_pkg::CNT_W'(eob_emit);
                push          = (eob_emit != '0);
                fill_next     = '0;
            end
            else if (is_full)
            begin
                cmd.start_pos = rlbe_pkg::POS_W'(BLK - PW'(1));
                cmd.count     = rlbe_pkg::CNT_W'(1);
                cmd.ovf       = 1'b1;
                push          = 1'b1;
            end
            else
            begin
                cmd.start_pos = rlbe_pkg::POS_W'(fill_reg);
                cmd.count     = rlbe_pkg::CNT_W'(emit);
                cmd.val_idx   = zero_run;
                cmd.value     = coeff_value;
                cmd.ovf       = cut;
                push          = 1'b1;
                fill_next     = fill_reg + PW'(emit);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // The fill position never passes the end of the block.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= BLK)
        else $error("fill position beyond block end");

    // A pushed job always carries at least one result.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> (cmd.count != '0))
        else $error("empty job pushed");

endmodule

// ----- hw/rtl/rlbe_queue.sv -----
// Short job queue between the front and back parts.
module rlbe_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rlbe_pkg::rlbe_cmd_t cmd_in,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output rlbe_pkg::rlbe_cmd_t head
);

    rlbe_pkg::rlbe_cmd_t             mem [rlbe_pkg::QUEUE_DEPTH];
    logic [rlbe_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [rlbe_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [rlbe_pkg::QCNT_W-1:0]     count_reg;

    assign full       = (count_reg == rlbe_pkg::QCNT_W'(rlbe_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cmd_in;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rlbe_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rlbe_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + rlbe_pkg::QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - rlbe_pkg::QCNT_W'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ----- hw/rtl/rlbe_back.sv -----
// Back part: expands the head job into one coefficient per cycle while the output can take it.
module rlbe_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  rlbe_pkg::rlbe_cmd_t                 head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rlbe_pkg::COEF_W-1:0]  coefficient,
    output logic [rlbe_pkg::POS_W-1:0]          position,
    output logic                                run_last,
    output logic                                overflow
);

    logic [rlbe_pkg::POS_W-1:0]         idx_reg;
    logic [rlbe_pkg::POS_W-1:0]         idx_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [rlbe_pkg::COEF_W-1:0] coef_reg;
    logic [rlbe_pkg::POS_W-1:0]         pos_reg;
    logic                               last_reg;
    logic                               ovf_reg;
    logic                               load;
    logic                               last;

    // Step through the head job while the output register can take a result.
    always_comb
    begin
        load = head_valid && (!out_valid_reg || out_ready);
        last = ((rlbe_pkg::CNT_W'(idx_reg) + rlbe_pkg::CNT_W'(1)) == head.count);
        pop  = load && last;
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = last ? '0 : idx_reg + rlbe_pkg::POS_W'(1);
        end
        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            coef_reg <= (idx_reg == head.val_idx) ? head.value : '0;
            pos_reg  <= head.start_pos + idx_reg;
            last_reg <= last;
            ovf_reg  <= head.ovf;
        end
    end

    assign out_valid   = out_valid_reg;
    assign coefficient = coef_reg;
    assign position    = pos_reg;
    assign run_last    = last_reg;
    assign overflow    = ovf_reg;

    // Within one request the positions advance by one per result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !run_last) |=>
            (out_valid && (position == $past(position) + rlbe_pkg::POS_W'(1))))
        else $error("position did not advance within a request");

    // Overflow flag is constant across the results of one request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !run_last) |=> (overflow == $past(overflow)))
        else $error("overflow flag changed within a request");

endmodule

// ----- dv/tb.sv -----
// Testbench for the run-length block expander: directed table plus random blocks vs predictor.
module tb;

    localparam int BLK_COEFFS   = 64;
    localparam int RANDOM_PAIRS = 140;
    localparam int MAX_WAIT     = 14;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 800000;

    // One expanded coefficient as it leaves the block.
    typedef struct packed {
        logic signed [rlbe_pkg::COEF_W-1:0] coefficient;
        logic [rlbe_pkg::POS_W-1:0]         position;
        logic                               run_last;
        logic                               overflow;
    } coeff_result_t;

    // One request of the directed table. Where typed is set, the results are
    // count zeros-or-value coefficients from first_pos, the last one carrying
    // last_coef, all with the given overflow flag.
    typedef struct packed {
        logic [rlbe_pkg::RUN_W-1:0]         run;
        logic signed [rlbe_pkg::COEF_W-1:0] value;
        logic                               typed;
        logic [rlbe_pkg::CNT_W-1:0]         count;
        logic [rlbe_pkg::POS_W-1:0]         first_pos;
        logic signed [rlbe_pkg::COEF_W-1:0] last_coef;
        logic                               ovf;
    } pair_row_t;

    localparam int DIRECTED_LEN = 23;
    localparam pair_row_t DIRECTED_PAIRS [DIRECTED_LEN] = '{
        // Single value right after reset, then end of block from position 1.
        '{6'd0,  16'sd5,     1'b1, 7'd1,  6'd0,  16'sd5,     1'b0},
        '{6'd0,  16'sd0,     1'b1, 7'd63, 6'd1,  16'sd0,     1'b0},
        // End of block on an empty block pads all 64 positions.
        '{6'd0,  16'sd0,     1'b1, 7'd64, 6'd0,  16'sd0,     1'b0},
        // Longest run fills the block exactly with the most negative value.
        '{6'd63, 16'h8000,   1'b1, 7'd64, 6'd0,  16'h8000,   1'b0},
        // End of block into a full block gives nothing.
        '{6'd0,  16'sd0,     1'b1, 7'd0,  6'd0,  16'sd0,     1'b0},
        '{6'd63, 16'sh7FFF,  1'b1, 7'd64, 6'd0,  16'sh7FFF,  1'b0},
        // Pair into a full block is dropped with one flagged zero.
        '{6'd3,  16'sd7,     1'b1, 7'd1,  6'd63, 16'sd0,     1'b1},
        '{6'd0,  16'sd0,     1'b1, 7'd0,  6'd0,  16'sd0,     1'b0},
        '{6'd10, 16'hFFFF,   1'b1, 7'd11, 6'd0,  16'hFFFF,   1'b0},
        // Run past block end: truncated, value lost.
        '{6'd60, 16'sd100,   1'b1, 7'd53, 6'd11, 16'sd0,     1'b1},
        '{6'd0,  16'sd1,     1'b1, 7'd1,  6'd63, 16'sd0,     1'b1},
        '{6'd0,  16'sd0,     1'b1, 7'd0,  6'd0,  16'sd0,     1'b0},
        // Zero value behind a nonzero run is an ordinary pair.
        '{6'd5,  16'sd0,     1'b1, 7'd6,  6'd0,  16'sd0,     1'b0},
        '{6'd0,  16'h8000,   1'b1, 7'd1,  6'd6,  16'h8000,   1'b0},
        '{6'd50, 16'sh5555,  1'b0, 7'd0,  6'd0,  16'sd0,     1'b0},
        '{6'd5,  16'sh2AAA,  1'b0, 7'd0,  6'd0,  16'sd0,     1'b0},
        '{6'd0,  16'sd0,     1'b0, 7'd0,  6'd0,  16'sd0,     1'b0},
        '{6'd62, 16'sd9,     1'b1, 7'd63, 6'd0,  16'sd9,     1'b0},
        // Run one past the last free slot: only the zero fits.
        '{6'd1,  16'sd3,     1'b1, 7'd1,  6'd63, 16'sd0,     1'b1},
        '{6'd0,  16'sd0,     1'b1, 7'd0,  6'd0,  16'sd0,     1'b0},
        '{6'd42, 16'sd1,     1'b0, 7'd0,  6'd0,  16'sd0,     1'b0},
        '{6'd7,  -16'sd12345, 1'b0, 7'd0, 6'd0,  16'sd0,     1'b0},
        '{6'd0,  16'sd0,     1'b0, 7'd0,  6'd0,  16'sd0,     1'b0}
    };

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic [rlbe_pkg::RUN_W-1:0]         zero_run;
    logic signed [rlbe_pkg::COEF_W-1:0] coeff_value;
    logic                               out_valid;
    logic                               out_ready;
    logic signed [rlbe_pkg::COEF_W-1:0] coefficient;
    logic [rlbe_pkg::POS_W-1:0]         position;
    logic                               run_last;
    logic                               overflow;

    coeff_result_t pending_coeffs[$];
    coeff_result_t expanded[$];
    int            fill_pos;
    int            mismatches;
    int            pairs_sent;
    int            cycle_count;
    bit            in_burst;
    bit            out_burst;
    int            out_hold;

    run_length_block_expander_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .zero_run    (zero_run),
        .coeff_value (coeff_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coefficient (coefficient),
        .position    (position),
        .run_last    (run_last),
        .overflow    (overflow)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic coeff_result_t make_coeff(
        input logic signed [rlbe_pkg::COEF_W-1:0] coef,
        input int pos, input bit last, input bit ovf);
        coeff_result_t r;
        r.coefficient = coef;
        r.position    = pos[rlbe_pkg::POS_W-1:0];
        r.run_last    = last;
        r.overflow    = ovf;
        return r;
    endfunction

    // Expands one pair at the current fill position into the scratch queue
    // and advances the fill position.
    function automatic void expand_pair(input logic [rlbe_pkg::RUN_W-1:0] run,
                                        input logic signed [rlbe_pkg::COEF_W-1:0] value);
        int p;
        int need;
        int room;
        int emit;
        bit ovf;
        expanded.delete();
        p = (fill_pos > BLK_COEFFS) ? BLK_COEFFS : fill_pos;
        if (run == 0 && value == 0)
        begin
            // End of block: pad the rest with zeros.
            emit = BLK_COEFFS - p;
            if (emit > rlbe_pkg::MAX_RESULTS)
                emit = rlbe_pkg::MAX_RESULTS;
            for (int i = 0; i < emit; i++)
                expanded.push_back(make_coeff(16'sd0, p + i, i + 1 == emit, 1'b0));
            fill_pos = 0;
        end
        else if (p >= BLK_COEFFS)
        begin
            // Block already full: the pair is dropped.
            expanded.push_back(make_coeff(16'sd0, BLK_COEFFS - 1, 1'b1, 1'b1));
            fill_pos = p;
        end
        else
        begin
            need = run + 1;
            room = BLK_COEFFS - p;
            emit = (need > room) ? room : need;
            ovf  = need > room;
            for (int i = 0; i < emit; i++)
                expanded.push_back(make_coeff((i == run) ? value : 16'sd0, p + i,
                                              i + 1 == emit, ovf));
            fill_pos = p + emit;
        end
    endfunction

    // Presents one request, waits for it to be taken and records what it
    // should produce.
    task automatic send_pair(input pair_row_t row);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        zero_run    <= row.run;
        coeff_value <= row.value;
        in_valid    <= 1'b1;
        do @(posedge clk); while (!in_ready);
        expand_pair(row.run, row.value);
        if (row.typed)
        begin
            for (int i = 0; i < row.count; i++)
                pending_coeffs.push_back(make_coeff((i == row.count - 1) ? row.last_coef
                                                                         : 16'sd0,
                                                    row.first_pos + i, i == row.count - 1,
                                                    row.ovf));
        end
        else
        begin
            foreach (expanded[i])
                pending_coeffs.push_back(expanded[i]);
        end
        pairs_sent++;
    endtask

    // Stops the sender until every outstanding coefficient has come out.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_coeffs.size() != 0);
    endtask

    // Random pair: mostly short runs, sometimes any run; value mostly nonzero.
    task automatic send_random_pair(input bit long_runs);
        pair_row_t row;
        row = '0;
        row.run = rlbe_pkg::RUN_W'((long_runs || $urandom_range(0, 3) == 0)
                                   ? $urandom_range(0, 63) : $urandom_range(0, 6));
        row.value = rlbe_pkg::COEF_W'($urandom);
        if ($urandom_range(0, 15) == 0)
            row.value = 16'sd0;
        send_pair(row);
    endtask

    // Stimulus: directed table, then random blocks.
    initial
    begin
        int npairs;
        int shape;
        pair_row_t eob;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        zero_run    = '0;
        coeff_value = '0;
        fill_pos    = 0;
        mismatches  = 0;
        pairs_sent  = 0;
        in_burst    = 1'b0;
        eob         = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_PAIRS[i])
            send_pair(DIRECTED_PAIRS[i]);
        hold_until_drained();

        // Mostly well-formed blocks ending in an end marker; some blocks run
        // over the end or skip the marker.
        while (pairs_sent < DIRECTED_LEN + RANDOM_PAIRS)
        begin
            shape    = $urandom_range(0, 9);
            in_burst = ($urandom_range(0, 3) == 0);
            npairs   = $urandom_range(0, 7);
            for (int k = 0; k < npairs; k++)
                send_random_pair(shape == 0);
            if (shape != 1)
                send_pair(eob);
            if ($urandom_range(0, 15) == 0)
                hold_until_drained();
        end

        in_valid <= 1'b0;
        while (pending_coeffs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: check each accepted coefficient and stall at random.
    initial
    begin
        coeff_result_t want;
        out_ready = 1'b1;
        out_hold  = 0;
        out_burst = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_coeffs.size() == 0)
                begin
                    $display("%0t: expected no coefficient, got %0d at position %0d",
                             $time, coefficient, position);
                    mismatches++;
                end
                else
                begin
                    want = pending_coeffs.pop_front();
                    if (coefficient !== want.coefficient)
                    begin
                        $display("%0t: coefficient expected %0d, got %0d", $time,
                                 want.coefficient, coefficient);
                        mismatches++;
                    end
                    if (position !== want.position)
                    begin
                        $display("%0t: position expected %0d, got %0d", $time,
                                 want.position, position);
                        mismatches++;
                    end
                    if (run_last !== want.run_last)
                    begin
                        $display("%0t: run_last expected %0b, got %0b", $time,
                                 want.run_last, run_last);
                        mismatches++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $display("%0t: overflow expected %0b, got %0b", $time,
                                 want.overflow, overflow);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    out_burst = ~out_burst;
                out_hold = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
                if (out_hold > 0)
                    out_ready <= 1'b0;
            end
            else if (out_hold > 0)
            begin
                out_hold--;
                if (out_hold == 0)
                    out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
